// ===== rtl/core/queue_with_middle_insert_defines.svh =====
// Assertion macros shared by the queue RTL.
`ifndef QUEUE_WITH_MIDDLE_INSERT_DEFINES_SVH
`define QUEUE_WITH_MIDDLE_INSERT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define QMI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define QMI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/qmi_pkg.sv =====
package qmi_pkg;

  localparam int WORD_W = 32;
  localparam int OCC_W  = 7;

  // Request kinds; the high bit alone selects a pop.
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_POP    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_POPPED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_POP_MOVE,
    S_PUSH_MOVE
  } state_t;

endpackage

// ===== rtl/core/qmi_ram.sv =====
module qmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/queue_with_middle_insert.sv =====
// Results: a store that needs no rebalancing, a rejected store and a pop from an empty
// queue load the result register in the accepting cycle; a pop from a non-empty queue,
// or a push that must move a word between halves, first passes through S_POP,
// S_POP_MOVE or S_PUSH_MOVE to wait on the registered read port of the two half-queue
// memories. A request is taken only in S_IDLE, so an operation ends before another starts.
// Reset: synchronous, active low; the queue becomes empty and the output word is
// dropped. Memory contents are not cleared and need not be.
`include "queue_with_middle_insert_defines.svh"

module queue_with_middle_insert #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] popped_word, [38:32] occupancy, [39] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  import qmi_pkg::*;

  // The queue is held as two ring buffers. The front half keeps the first
  // ceil(n/2) words and the back half the rest, so that the middle position is
  // always the head of the back half. Every request touches at most the head of
  // each half, the tail of each half, and moves at most one word from the back
  // head to the front tail to keep the halves balanced.
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = PW + 1;
  localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_N  = (CW + 1)'(QUEUE_DEPTH);

  state_t                     state_r, state_nxt;
  logic [PW-1:0]              f_head_r, f_head_nxt;
  logic [PW-1:0]              b_head_r, b_head_nxt;
  logic [CW-1:0]              f_cnt_r, f_cnt_nxt;
  logic [CW-1:0]              b_cnt_r, b_cnt_nxt;
  logic signed [WORD_W-1:0]   word_r, word_nxt;

  logic                       out_valid_r, out_valid_nxt;
  status_t                    out_status_r, out_status_nxt;
  logic signed [WORD_W-1:0]   out_word_r, out_word_nxt;
  logic [OCC_W-1:0]           out_occ_r, out_occ_nxt;

  // Memory ports.
  logic                       f_we, b_we;
  logic [PW-1:0]              f_waddr, b_waddr;
  logic [WORD_W-1:0]          f_wdata, b_wdata;
  logic [WORD_W-1:0]          f_rdata, b_rdata;

  // Decoded request and derived pointers.
  logic signed [WORD_W-1:0]   in_value;
  logic [1:0]                 in_mode;
  logic                       accept;
  logic                       is_pop;
  logic                       is_ins;
  logic [CW:0]                n_sum;
  logic [CW-1:0]              n_cnt;
  logic                       even;
  logic                       empty;
  logic                       full;
  logic [SW-1:0]              f_tail_sum, b_tail_sum;
  logic [PW-1:0]              f_tail, b_tail;
  logic [PW-1:0]              f_head_inc, b_head_inc, b_head_dec;
  logic                       out_load;
  logic [CW-1:0]              occ_cnt;
  logic [CW+OCC_W-1:0]        occ_ext;

  assign in_value = in_tdata;
  assign in_mode  = in_tuser;
  assign is_pop   = in_mode[1];          // mode 3 behaves as a pop too
  assign is_ins   = (in_mode == MODE_INSERT);

  // New requests are taken only between operations and when the result register
  // is free, or is being emptied in this cycle.
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign n_sum = {1'b0, f_cnt_r} + {1'b0, b_cnt_r};
  assign n_cnt = n_sum[CW-1:0];
  assign even  = (f_cnt_r == b_cnt_r);
  assign empty = (n_sum == '0);
  assign full  = (n_sum >= DEPTH_N);

  // Ring arithmetic: the tail index is head plus count, folded once.
  assign f_tail_sum = SW'(f_head_r) + SW'(f_cnt_r);
  assign b_tail_sum = SW'(b_head_r) + SW'(b_cnt_r);
  assign f_tail = (f_tail_sum >= DEPTH_S) ? PW'(f_tail_sum - DEPTH_S) : PW'(f_tail_sum);
  assign b_tail = (b_tail_sum >= DEPTH_S) ? PW'(b_tail_sum - DEPTH_S) : PW'(b_tail_sum);

  assign f_head_inc = (f_head_r == LAST_IDX) ? '0 : f_head_r + 1'b1;
  assign b_head_inc = (b_head_r == LAST_IDX) ? '0 : b_head_r + 1'b1;
  assign b_head_dec = (b_head_r == '0) ? LAST_IDX : b_head_r - 1'b1;

  // Both memories read their head entry continuously. Every operation that
  // needs a head word reads it in the cycle after acceptance, and no write
  // happens in the accepting cycle of such an operation, so the read never
  // races a write to the same entry.
  qmi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_front_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_head_r),
    .rdata (f_rdata)
  );

  qmi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_back_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_head_r),
    .rdata (b_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    f_head_nxt     = f_head_r;
    b_head_nxt     = b_head_r;
    f_cnt_nxt      = f_cnt_r;
    b_cnt_nxt      = b_cnt_r;
    word_nxt       = word_r;
    f_we           = 1'b0;
    f_waddr        = f_tail;
    f_wdata        = in_value;
    b_we           = 1'b0;
    b_waddr        = b_tail;
    b_wdata        = in_value;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_word_nxt   = '0;
    occ_cnt        = n_cnt;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_pop) begin
            if (empty) begin
              out_load       = 1'b1;
              out_status_nxt = ST_EMPTY;
            end else if (even) begin
              // The front half shrinks below the back half: refill it from the back.
              state_nxt = S_POP_MOVE;
            end else begin
              state_nxt = S_POP;
            end
          end else if (full) begin
            out_load       = 1'b1;
            out_status_nxt = ST_FULL;
          end else if (even && (in_mode != MODE_PUSH || empty)) begin
            // Balanced halves: a middle word lands at the front tail, as does the
            // first word into an empty queue.
            f_we           = 1'b1;
            f_cnt_nxt      = f_cnt_r + 1'b1;
            out_load       = 1'b1;
            out_status_nxt = ST_STORED;
            occ_cnt        = n_cnt + 1'b1;
          end else if (even) begin
            // A push onto balanced halves: the back head has to move forward,
            // which needs its word from memory first.
            word_nxt  = in_value;
            state_nxt = S_PUSH_MOVE;
          end else if (is_ins) begin
            b_we           = 1'b1;
            b_waddr        = b_head_dec;
            b_head_nxt     = b_head_dec;
            b_cnt_nxt      = b_cnt_r + 1'b1;
            out_load       = 1'b1;
            out_status_nxt = ST_STORED;
            occ_cnt        = n_cnt + 1'b1;
          end else begin
            b_we           = 1'b1;
            b_cnt_nxt      = b_cnt_r + 1'b1;
            out_load       = 1'b1;
            out_status_nxt = ST_STORED;
            occ_cnt        = n_cnt + 1'b1;
          end
        end
      end

      S_POP: begin
        f_head_nxt     = f_head_inc;
        f_cnt_nxt      = f_cnt_r - 1'b1;
        out_load       = 1'b1;
        out_status_nxt = ST_POPPED;
        out_word_nxt   = f_rdata;
        occ_cnt        = n_cnt - 1'b1;
        state_nxt      = S_IDLE;
      end

      S_POP_MOVE: begin
        // The word goes to the old front tail index, which is the new last entry after the head advances.
        f_head_nxt     = f_head_inc;
        f_we           = 1'b1;
        f_wdata        = b_rdata;
        b_head_nxt     = b_head_inc;
        b_cnt_nxt      = b_cnt_r - 1'b1;
        out_load       = 1'b1;
        out_status_nxt = ST_POPPED;
        out_word_nxt   = f_rdata;
        occ_cnt        = n_cnt - 1'b1;
        state_nxt      = S_IDLE;
      end

      S_PUSH_MOVE: begin
        b_we           = 1'b1;
        b_wdata        = word_r;
        b_head_nxt     = b_head_inc;
        f_we           = 1'b1;
        f_wdata        = b_rdata;
        f_cnt_nxt      = f_cnt_r + 1'b1;
        out_load       = 1'b1;
        out_status_nxt = ST_STORED;
        occ_cnt        = n_cnt + 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Occupancy carries the low bits of the count.
  assign occ_ext     = {{OCC_W{1'b0}}, occ_cnt};
  assign out_occ_nxt = occ_ext[OCC_W-1:0];

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      f_head_r    <= '0;
      b_head_r    <= '0;
      f_cnt_r     <= '0;
      b_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      f_head_r    <= f_head_nxt;
      b_head_r    <= b_head_nxt;
      f_cnt_r     <= f_cnt_nxt;
      b_cnt_r     <= b_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_word_r   <= out_word_nxt;
      out_occ_r    <= out_occ_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_occ_r, out_word_r};

  `QMI_ASSERT(a_halves_balanced,
              (f_cnt_r == b_cnt_r) || (f_cnt_r == b_cnt_r + 1'b1),
              "queue halves out of balance")
  `QMI_ASSERT(a_count_bound, n_sum <= DEPTH_N, "entry count beyond queue depth")
  `QMI_ASSERT(a_busy_out_free, (state_r != S_IDLE) |-> !out_valid_r,
              "result register busy during an operation")
  `QMI_ASSERT(a_pop_result,
              (state_r == S_POP || state_r == S_POP_MOVE) |=>
              (out_valid_r && out_status_r == ST_POPPED),
              "pop finished without a popped result")
  `QMI_ASSERT_RST(a_reset_empty,
                  !rst_n |=> (f_cnt_r == '0 && b_cnt_r == '0 && !out_valid_r &&
                              state_r == S_IDLE),
                  "reset did not empty the queue")

endmodule
